@@ src/prpi_pkg.sv @@
// shared types, codes and helpers for the periodic rate profile integrator
package prpi_pkg;

	localparam int unsigned TIME_W  = 40;
	localparam int unsigned WORK_W  = 48;
	localparam int unsigned DUR_W   = 24;
	localparam int unsigned RATE_W  = 16;
	localparam int unsigned START_W = 30;
	localparam int unsigned PREF_W  = 46;
	localparam int unsigned DVD_W   = 49;
	localparam int unsigned MULX_W  = 50;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned STAT_W  = 3;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INTEG  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SOLVE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RATE   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_REVERSED = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_ZERO     = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVF      = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_APP2, S_DIV_B, S_DIV_A, S_MUL_DQ, S_SCAN_RD, S_SCAN_CMP,
		S_FETCH, S_FETCH_W, S_DIV_W, S_DIV_C, S_DIV_F, S_MUL_N, S_DONE
	} prpi_state_t;

	typedef enum logic [2:0] {
		STEP_PWB, STEP_PWA, STEP_RATE, STEP_SOLVE_PW, STEP_OFFSET
	} prpi_step_t;

	typedef struct packed {
		logic              done;
		logic [DVD_W-1:0]  quot;
		logic [PREF_W-1:0] rem;
	} prpi_div_res_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [WORK_W-1:0] prod;
	} prpi_mul_res_t;

	typedef struct packed {
		logic [WORK_W-1:0] value;
		logic [STAT_W-1:0] status;
	} prpi_res_t;

	// saturate a wide result to 48 bits
	function automatic prpi_res_t sat48(input logic [55:0] x);
		prpi_res_t r;
		if (|x[55:48]) begin
			r.value  = '1;
			r.status = ST_OVF;
		end else begin
			r.value  = x[47:0];
			r.status = ST_OK;
		end
		return r;
	endfunction

endpackage

@@ src/prpi_div.sv @@
// restoring serial divider, one quotient bit per cycle
module prpi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [prpi_pkg::DVD_W-1:0]  dividend,
	input  logic [prpi_pkg::PREF_W-1:0] divisor,
	output prpi_pkg::prpi_div_res_t     res
);
	import prpi_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [DVD_W-1:0]  quo_q;
	logic [PREF_W-1:0] rem_q;
	logic [PREF_W-1:0] dvs_q;
	logic [PREF_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? PREF_W'(trial - {1'b0, dvs_q}) : trial[PREF_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

@@ src/prpi_mul.sv @@
// shift-add serial multiplier with 48-bit overflow detect
module prpi_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [prpi_pkg::MULX_W-1:0] x,
	input  logic [prpi_pkg::PREF_W-1:0] y,
	output prpi_pkg::prpi_mul_res_t     res
);
	import prpi_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [5:0]        cnt_q;
	logic [MULX_W-1:0] x_q;
	logic [PREF_W-1:0] y_q;
	logic [MULX_W-1:0] acc_q;
	logic [MULX_W-1:0] nacc;

	assign nacc = {acc_q[MULX_W-2:0], 1'b0} + (x_q[MULX_W-1] ? MULX_W'(y_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(MULX_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			x_q <= {x_q[MULX_W-2:0], 1'b0};
			// once past 48 bits the product only grows, so the flag sticks
			if (!ovf_q) begin
				if (|nacc[MULX_W-1:WORK_W]) begin
					ovf_q <= 1'b1;
				end else begin
					acc_q <= nacc;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.prod = acc_q[WORK_W-1:0];

endmodule

@@ src/periodic_rate_profile_integrator_unit.sv @@
// top level of the periodic rate profile integrator
// Keeps a periodic piecewise-constant rate profile in two synchronous memories: one holds
// the start time and prefix work of each segment (one extra entry marks the period end),
// the other holds the segment rates. One command word is worked at a time and gives one
// result word. Clear, append and the fixed-rate forms of integrate and rate need no serial
// unit; a fixed-rate solve adds one serial division. Segment-mode commands run through
// the serial divider, the serial multiplier and linear scans of the segment memory,
// which take a read state and a compare state per entry. A new command word is taken
// while the previous result still waits in the output register. The memories have no
// reset and no clearing pass; only entries below the segment count are ever read.
module periodic_rate_profile_integrator_unit #(
	parameter int unsigned MAX_SEGMENTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [prpi_pkg::RATE_W-1:0] cfg_wr_data,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [prpi_pkg::CMD_W-1:0]  command,
	input  logic [prpi_pkg::TIME_W-1:0] time_a,
	input  logic [prpi_pkg::TIME_W-1:0] time_b,
	input  logic [prpi_pkg::WORK_W-1:0] work_amount,
	input  logic [prpi_pkg::DUR_W-1:0]  seg_duration,
	input  logic [prpi_pkg::RATE_W-1:0] seg_rate,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [prpi_pkg::WORK_W-1:0] value,
	output logic [prpi_pkg::STAT_W-1:0] status
);
	import prpi_pkg::*;

	// segment index width covers the period end entry; rate index only the segments
	localparam int unsigned AW    = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned RIW   = $clog2(MAX_SEGMENTS);
	localparam int unsigned SP_W  = START_W + PREF_W;

	// segment memories
	logic [SP_W-1:0]   sp_mem [MAX_SEGMENTS+1];
	logic [RATE_W-1:0] rate_mem [MAX_SEGMENTS];
	logic [SP_W-1:0]   sp_rd_q;
	logic [RATE_W-1:0] rate_rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [SP_W-1:0]   mem_wd;
	logic              rate_we;
	logic [AW-1:0]     rd_addr;

	// profile state
	logic [AW-1:0]      count_q;
	logic [START_W-1:0] plen_q;
	logic [PREF_W-1:0]  pwork_q;
	logic [RATE_W-1:0]  drate_q;
	logic [RATE_W-1:0]  rate0_q;

	// command word in flight
	logic [CMD_W-1:0]  cmd_q;
	logic [TIME_W-1:0] a_q;
	logic [TIME_W-1:0] b_q;
	logic [WORK_W-1:0] amt_q;
	logic [DUR_W-1:0]  dur_q;
	logic [RATE_W-1:0] srate_q;

	// working registers
	prpi_state_t        state_q, state_d;
	prpi_step_t         step_q;
	logic [TIME_W-1:0]  qb_q;
	logic [START_W-1:0] rb_q;
	logic [TIME_W-1:0]  qa_q;
	logic [START_W-1:0] ra_q;
	logic [MULX_W-1:0]  acc_q;
	logic [PREF_W-1:0]  key_q;
	logic [AW-1:0]      k_q;
	logic [AW-1:0]      idx_q;
	logic [DVD_W-1:0]   q2_q;
	logic [START_W-1:0] rs_q;
	logic [START_W+17-1:0] r_q;
	prpi_res_t          res_q;

	// output register
	logic              res_valid_q;
	prpi_res_t         out_q;

	// shared units
	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [PREF_W-1:0] div_dvs;
	prpi_div_res_t     div_res;
	logic              mul_start;
	logic [MULX_W-1:0] mul_x;
	logic [PREF_W-1:0] mul_y;
	prpi_mul_res_t     mul_res;

	// combinational helpers
	logic                fixed;
	logic [RATE_W-1:0]   frate;
	logic                app_full;
	logic [START_W:0]    len_sum;
	logic [39:0]         seg_work;
	logic [PREF_W:0]     work_sum;
	logic                app_ovf;
	logic [55:0]         int_prod;
	logic [DVD_W-1:0]    ceil_num;
	logic [START_W-1:0]  start_rd;
	logic [PREF_W-1:0]   prefix_rd;
	logic [PREF_W-1:0]   pw;
	logic [MULX_W-1:0]   acc_plus;
	logic [MULX_W-1:0]   acc_minus;
	logic [DVD_W-1:0]    wr_sum;
	logic [PREF_W-1:0]   need;
	logic [MULX_W-1:0]   n_sum;
	logic                scan_hit;
	logic                out_free;

	prpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.res      (div_res)
	);

	prpi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.res    (mul_res)
	);

	// zero or one segment runs at a single fixed rate
	assign fixed    = count_q <= AW'(1);
	assign frate    = (count_q == '0) ? drate_q : rate0_q;
	assign app_full = count_q >= AW'(MAX_SEGMENTS);
	assign len_sum  = {1'b0, plen_q} + (START_W+1)'(dur_q);
	assign seg_work = dur_q * srate_q;
	assign work_sum = {1'b0, pwork_q} + (PREF_W+1)'(seg_work);
	assign app_ovf  = len_sum[START_W] | work_sum[PREF_W];
	assign int_prod = (b_q - a_q) * frate;
	// ceiling division for fixed-rate solve
	assign ceil_num = DVD_W'(amt_q) + DVD_W'(frate) - DVD_W'(1);

	assign start_rd  = sp_rd_q[SP_W-1:PREF_W];
	assign prefix_rd = sp_rd_q[PREF_W-1:0];
	// work from period start to offset key within the fetched segment
	assign pw        = prefix_rd + PREF_W'(rate_rd_q * (key_q[START_W-1:0] - start_rd));
	assign acc_plus  = acc_q + MULX_W'(pw);
	assign acc_minus = acc_q - MULX_W'(pw);
	assign wr_sum    = DVD_W'(amt_q) + DVD_W'(pw);
	assign need      = key_q - prefix_rd;
	assign n_sum     = MULX_W'(qa_q) + MULX_W'(q2_q);

	// index scan keeps the last segment starting at or before the offset, or for solve
	// walks on while the next prefix is still short of the remaining work
	assign scan_hit = (step_q == STEP_OFFSET) ? (prefix_rd < key_q)
	                                          : (PREF_W'(start_rd) <= key_q);

	assign out_free  = !res_valid_q || res_ready;
	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign value     = out_q.value;
	assign status    = out_q.status;

	// memory ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			sp_mem[mem_wa] <= mem_wd;
		end
		if (rate_we) begin
			rate_mem[count_q[RIW-1:0]] <= srate_q;
		end
		sp_rd_q   <= sp_mem[rd_addr];
		rate_rd_q <= rate_mem[rd_addr[RIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and unit strobes
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		mul_start = 1'b0;
		mul_x     = '0;
		mul_y     = '0;
		mem_we    = 1'b0;
		mem_wa    = count_q;
		mem_wd    = {plen_q, pwork_q};
		rate_we   = 1'b0;
		rd_addr   = k_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (cmd_q)
					CMD_APPEND: begin
						if (!app_full && !app_ovf) begin
							mem_we  = 1'b1;
							rate_we = 1'b1;
							state_d = S_APP2;
						end
					end
					CMD_INTEG: begin
						if (a_q < b_q && !fixed && plen_q != '0) begin
							div_start = 1'b1;
							div_dvd   = DVD_W'(b_q);
							div_dvs   = PREF_W'(plen_q);
							state_d   = S_DIV_B;
						end
					end
					CMD_SOLVE: begin
						if (amt_q != '0) begin
							if (fixed) begin
								if (frate != '0) begin
									div_start = 1'b1;
									div_dvd   = ceil_num;
									div_dvs   = PREF_W'(frate);
									state_d   = S_DIV_F;
								end
							end else if (plen_q != '0 && pwork_q != '0) begin
								div_start = 1'b1;
								div_dvd   = DVD_W'(a_q);
								div_dvs   = PREF_W'(plen_q);
								state_d   = S_DIV_A;
							end
						end
					end
					CMD_RATE: begin
						if (!fixed && plen_q != '0) begin
							div_start = 1'b1;
							div_dvd   = DVD_W'(a_q);
							div_dvs   = PREF_W'(plen_q);
							state_d   = S_DIV_A;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_APP2: begin
				// period end entry, count already advanced
				mem_we  = 1'b1;
				state_d = S_DONE;
			end
			S_DIV_B: begin
				if (div_res.done) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(a_q);
					div_dvs   = PREF_W'(plen_q);
					state_d   = S_DIV_A;
				end
			end
			S_DIV_A: begin
				if (div_res.done) begin
					if (cmd_q == CMD_INTEG) begin
						mul_start = 1'b1;
						mul_x     = MULX_W'(qb_q - div_res.quot[TIME_W-1:0]);
						mul_y     = pwork_q;
						state_d   = S_MUL_DQ;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_MUL_DQ: begin
				if (mul_res.done) begin
					state_d = mul_res.ovf ? S_DONE : S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = (k_q >= count_q) ? S_FETCH : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				state_d = scan_hit ? S_SCAN_RD : S_FETCH;
			end
			S_FETCH: begin
				rd_addr = idx_q;
				state_d = S_FETCH_W;
			end
			S_FETCH_W: begin
				case (step_q)
					STEP_PWB: begin
						state_d = S_SCAN_RD;
					end
					STEP_SOLVE_PW: begin
						div_start = 1'b1;
						div_dvd   = wr_sum;
						div_dvs   = pwork_q;
						state_d   = S_DIV_W;
					end
					STEP_OFFSET: begin
						if (rate_rd_q == '0) begin
							mul_start = 1'b1;
							mul_x     = n_sum;
							mul_y     = PREF_W'(plen_q);
							state_d   = S_MUL_N;
						end else begin
							div_start = 1'b1;
							div_dvd   = DVD_W'(need);
							div_dvs   = PREF_W'(rate_rd_q);
							state_d   = S_DIV_C;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_DIV_W: begin
				if (div_res.done) begin
					state_d = S_SCAN_RD;
				end
			end
			S_DIV_C: begin
				if (div_res.done) begin
					mul_start = 1'b1;
					mul_x     = n_sum;
					mul_y     = PREF_W'(plen_q);
					state_d   = S_MUL_N;
				end
			end
			S_DIV_F: begin
				if (div_res.done) begin
					state_d = S_DONE;
				end
			end
			S_MUL_N: begin
				if (mul_res.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// profile state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			plen_q  <= '0;
			pwork_q <= '0;
			drate_q <= RATE_W'(4096);
		end else begin
			if (cfg_wr_en) begin
				drate_q <= cfg_wr_data;
			end
			if (state_q == S_DISP) begin
				if (cmd_q == CMD_CLEAR) begin
					count_q <= '0;
					plen_q  <= '0;
					pwork_q <= '0;
				end else if (cmd_q == CMD_APPEND && !app_full && !app_ovf) begin
					count_q <= count_q + AW'(1);
					plen_q  <= len_sum[START_W-1:0];
					pwork_q <= work_sum[PREF_W-1:0];
				end
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q   <= command;
					a_q     <= time_a;
					b_q     <= time_b;
					amt_q   <= work_amount;
					dur_q   <= seg_duration;
					srate_q <= seg_rate;
				end
			end
			S_DISP: begin
				case (cmd_q)
					CMD_APPEND: begin
						if (app_full) begin
							res_q <= '{value: '0, status: ST_FULL};
						end else if (app_ovf) begin
							res_q <= '{value: '0, status: ST_OVF};
						end else begin
							res_q <= '{value: '0, status: ST_OK};
							if (count_q == '0) begin
								// first segment rate kept aside for fixed mode
								rate0_q <= srate_q;
							end
						end
					end
					CMD_INTEG: begin
						if (a_q > b_q) begin
							res_q <= '{value: '0, status: ST_REVERSED};
						end else if (a_q != b_q && fixed) begin
							res_q <= sat48(int_prod);
						end else if (a_q != b_q && plen_q == '0) begin
							res_q <= '{value: '0, status: ST_ZERO};
						end else begin
							res_q <= '{value: '0, status: ST_OK};
						end
					end
					CMD_SOLVE: begin
						if (amt_q == '0) begin
							res_q <= '{value: WORK_W'(a_q), status: ST_OK};
						end else if (fixed ? (frate == '0) : (plen_q == '0 || pwork_q == '0)) begin
							res_q <= '{value: '0, status: ST_ZERO};
						end else begin
							res_q <= '{value: '0, status: ST_OK};
						end
					end
					CMD_RATE: begin
						if (fixed) begin
							res_q <= '{value: WORK_W'(frate), status: ST_OK};
						end else if (plen_q == '0) begin
							res_q <= '{value: '0, status: ST_ZERO};
						end else begin
							res_q <= '{value: '0, status: ST_OK};
						end
					end
					default: begin
						res_q <= '{value: '0, status: ST_OK};
					end
				endcase
			end
			S_DIV_B: begin
				if (div_res.done) begin
					qb_q <= div_res.quot[TIME_W-1:0];
					rb_q <= div_res.rem[START_W-1:0];
				end
			end
			S_DIV_A: begin
				if (div_res.done) begin
					qa_q <= div_res.quot[TIME_W-1:0];
					ra_q <= div_res.rem[START_W-1:0];
					if (cmd_q != CMD_INTEG) begin
						key_q  <= PREF_W'(div_res.rem[START_W-1:0]);
						step_q <= (cmd_q == CMD_SOLVE) ? STEP_SOLVE_PW : STEP_RATE;
						k_q    <= AW'(1);
						idx_q  <= '0;
					end
				end
			end
			S_MUL_DQ: begin
				if (mul_res.done) begin
					if (mul_res.ovf) begin
						res_q <= '{value: '1, status: ST_OVF};
					end else begin
						acc_q  <= MULX_W'(mul_res.prod);
						key_q  <= PREF_W'(rb_q);
						step_q <= STEP_PWB;
						k_q    <= AW'(1);
						idx_q  <= '0;
					end
				end
			end
			S_SCAN_CMP: begin
				if (scan_hit) begin
					idx_q <= k_q;
					k_q   <= k_q + AW'(1);
				end
			end
			S_FETCH_W: begin
				case (step_q)
					STEP_PWB: begin
						acc_q  <= acc_plus;
						key_q  <= PREF_W'(ra_q);
						step_q <= STEP_PWA;
						k_q    <= AW'(1);
						idx_q  <= '0;
					end
					STEP_PWA: begin
						res_q <= sat48(56'(acc_minus));
					end
					STEP_RATE: begin
						res_q <= '{value: WORK_W'(rate_rd_q), status: ST_OK};
					end
					STEP_OFFSET: begin
						rs_q <= start_rd;
						r_q  <= (START_W+17)'(start_rd);
					end
					default: begin
						rs_q <= start_rd;
					end
				endcase
			end
			S_DIV_W: begin
				if (div_res.done) begin
					// an exact multiple ends at the close of the previous period
					if (div_res.rem == '0) begin
						q2_q  <= div_res.quot - DVD_W'(1);
						key_q <= pwork_q;
					end else begin
						q2_q  <= div_res.quot;
						key_q <= div_res.rem;
					end
					step_q <= STEP_OFFSET;
					k_q    <= AW'(1);
					idx_q  <= '0;
				end
			end
			S_DIV_C: begin
				if (div_res.done) begin
					r_q <= (START_W+17)'(rs_q) + (START_W+17)'(div_res.quot[PREF_W-1:0])
					       + (START_W+17)'(div_res.rem != '0);
				end
			end
			S_DIV_F: begin
				if (div_res.done) begin
					res_q <= sat48(56'(MULX_W'(a_q) + MULX_W'(div_res.quot)));
				end
			end
			S_MUL_N: begin
				if (mul_res.done) begin
					if (mul_res.ovf) begin
						res_q <= '{value: '1, status: ST_OVF};
					end else begin
						res_q <= sat48(56'(MULX_W'(mul_res.prod) + MULX_W'(r_q)));
					end
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

endmodule

@@ bench/tb_periodic_rate_profile_integrator_unit.sv @@
// testbench for the periodic rate profile integrator: directed and random commands vs a predictor
module tb_periodic_rate_profile_integrator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import prpi_pkg::*;

	// command codes the block ignores
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam int unsigned SEGS       = 64;
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned M46 = 64'h3FFF_FFFF_FFFF;
	localparam longint unsigned M30 = 64'h3FFF_FFFF;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [RATE_W-1:0]   cfg_wr_data = '0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	logic [CMD_W-1:0]    command = '0;
	logic [TIME_W-1:0]   time_a = '0;
	logic [TIME_W-1:0]   time_b = '0;
	logic [WORK_W-1:0]   work_amount = '0;
	logic [DUR_W-1:0]    seg_duration = '0;
	logic [RATE_W-1:0]   seg_rate = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	logic [WORK_W-1:0]   value;
	logic [STAT_W-1:0]   status;

	periodic_rate_profile_integrator_unit #(.MAX_SEGMENTS(SEGS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.command(command), .time_a(time_a), .time_b(time_b),
		.work_amount(work_amount), .seg_duration(seg_duration), .seg_rate(seg_rate),
		.res_valid(res_valid), .res_ready(res_ready),
		.value(value), .status(status)
	);

	always #4 clk = ~clk;

	// predictor copy of the profile table
	longint unsigned seg_start [0:SEGS];
	longint unsigned seg_prefix [0:SEGS];
	longint unsigned seg_rt [0:SEGS-1];
	int unsigned     seg_total;
	longint unsigned prof_len;
	longint unsigned prof_work;
	longint unsigned base_rate;

	prpi_res_t pending_answers[$];
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned words_checked = 0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;
	bit          calm = 1'b0;

	// last segment starting at or before offset r
	function automatic int unsigned seg_at(longint unsigned r);
		int unsigned i;
		i = 0;
		for (int unsigned k = 1; k < seg_total; k++)
			if (seg_start[k] <= r) i = k;
		return i;
	endfunction

	function automatic longint unsigned work_to(longint unsigned r);
		int unsigned i;
		i = seg_at(r);
		return seg_prefix[i] + seg_rt[i] * (r - seg_start[i]);
	endfunction

	// earliest offset where work since period start reaches rem
	function automatic longint unsigned offset_for(longint unsigned rem);
		int unsigned i;
		longint unsigned need;
		i = 0;
		while (i + 1 < seg_total && seg_prefix[i+1] < rem) i++;
		need = rem - seg_prefix[i];
		if (seg_rt[i] == 0) return seg_start[i];
		return seg_start[i] + (need + seg_rt[i] - 1) / seg_rt[i];
	endfunction

	// expected answer of one command word, updating the profile copy
	function automatic prpi_res_t profile_answer(logic [CMD_W-1:0] c, longint unsigned a,
			longint unsigned b, longint unsigned amt, longint unsigned dur,
			longint unsigned srate);
		prpi_res_t r;
		longint unsigned v, rt, dq, qa, wr, q2, rem, n, off;
		bit fixed;
		v = 0;
		r.status = ST_OK;
		fixed = seg_total <= 1;
		rt = (seg_total == 0) ? base_rate : seg_rt[0];
		case (c)
			CMD_CLEAR: begin
				seg_total = 0; prof_len = 0; prof_work = 0;
			end
			CMD_APPEND: begin
				if (seg_total >= SEGS) r.status = ST_FULL;
				else if (prof_len + dur > M30 || prof_work + dur * srate > M46)
					r.status = ST_OVF;
				else begin
					seg_start[seg_total] = prof_len;
					seg_prefix[seg_total] = prof_work;
					seg_rt[seg_total] = srate;
					prof_len += dur;
					prof_work += dur * srate;
					seg_total++;
					seg_start[seg_total] = prof_len;
					seg_prefix[seg_total] = prof_work;
				end
			end
			CMD_INTEG: begin
				if (a > b) r.status = ST_REVERSED;
				else if (a == b) v = 0;
				else if (fixed) begin
					v = (b - a) * rt;
					if (v > M48) begin v = M48; r.status = ST_OVF; end
				end else if (prof_len == 0) r.status = ST_ZERO;
				else begin
					dq = b / prof_len - a / prof_len;
					if (prof_work != 0 && dq > M48 / prof_work) begin
						v = M48; r.status = ST_OVF;
					end else begin
						v = dq * prof_work + work_to(b % prof_len) - work_to(a % prof_len);
						if (v > M48) begin v = M48; r.status = ST_OVF; end
					end
				end
			end
			CMD_SOLVE: begin
				if (amt == 0) v = a;
				else if (fixed) begin
					if (rt == 0) r.status = ST_ZERO;
					else begin
						v = a + (amt + rt - 1) / rt;
						if (v > M48) begin v = M48; r.status = ST_OVF; end
					end
				end else if (prof_len == 0 || prof_work == 0) r.status = ST_ZERO;
				else begin
					qa = a / prof_len;
					wr = work_to(a % prof_len) + amt;
					q2 = wr / prof_work;
					rem = wr % prof_work;
					if (rem == 0) begin q2--; rem = prof_work; end
					off = offset_for(rem);
					n = qa + q2;
					if (n > M48 / prof_len) begin v = M48; r.status = ST_OVF; end
					else begin
						v = n * prof_len + off;
						if (v > M48) begin v = M48; r.status = ST_OVF; end
					end
				end
			end
			CMD_RATE: begin
				if (fixed) v = rt;
				else if (prof_len == 0) r.status = ST_ZERO;
				else v = seg_rt[seg_at(a % prof_len)];
			end
			default: ;
		endcase
		r.value = v[47:0];
		return r;
	endfunction

	// mostly short gaps, a few long, none in calm stretches
	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (calm || p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side back-pressure
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ready = 1'b0;
				stall_left--;
			end else begin
				res_ready = 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		prpi_res_t want;
		if (res_valid && res_ready) begin
			words_checked++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result value=%h status=%0d", $time, value, status);
			end else begin
				want = pending_answers.pop_front();
				if (value !== want.value) begin
					mismatches++;
					$display("%0t value mismatch: expected %h actual %h",
						$time, want.value, value);
				end
				if (status !== want.status) begin
					mismatches++;
					$display("%0t status mismatch: expected %0d actual %0d",
						$time, want.status, status);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t watchdog: no progress, %0d answers pending",
				$time, pending_answers.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// send one command word and queue its expected answer
	task automatic send_word(logic [CMD_W-1:0] c, logic [TIME_W-1:0] a, logic [TIME_W-1:0] b,
			logic [WORK_W-1:0] amt, logic [DUR_W-1:0] dur, logic [RATE_W-1:0] srate);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
		command = c; time_a = a; time_b = b; work_amount = amt;
		seg_duration = dur; seg_rate = srate;
		cmd_valid = 1'b1;
		do @(posedge clk); while (!cmd_ready);
		pending_answers.insert(pending_answers.size(),
			profile_answer(c, 64'(a), 64'(b), 64'(amt), 64'(dur), 64'(srate)));
		words_sent++;
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_default_rate(logic [RATE_W-1:0] r);
		wait_drained();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = r;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		base_rate = 64'(r);
	endtask

	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(0, 2))
			0: return TIME_W'($urandom_range(0, 4095));
			1: return TIME_W'($urandom_range(0, 32'hFF_FFFF));
			default: return TIME_W'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic logic [WORK_W-1:0] rand_work();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return WORK_W'($urandom_range(1, 65535));
			2: return WORK_W'($urandom());
			default: return WORK_W'({$urandom(), $urandom()});
		endcase
	endfunction

	// fixed rate: default rate, empty and reversed intervals, rounding, overflow
	task automatic test_fixed_rate();
		send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
		send_word(CMD_RATE, '0, '0, '0, '0, '0);
		send_word(CMD_INTEG, 40'd10, 40'd20, '0, '0, '0);
		send_word(CMD_INTEG, 40'd20, 40'd10, '0, '0, '0);
		send_word(CMD_INTEG, 40'd7, 40'd7, '0, '0, '0);
		send_word(CMD_SOLVE, 40'd99, '0, '0, '0, '0);
		send_word(CMD_SOLVE, 40'd5, '0, 48'd4097, '0, '0);
		send_word(CMD_UNUSED_LO, '1, '1, '1, '1, '1);
		send_word(CMD_UNUSED_HI, '0, '0, '0, '0, '0);
		write_default_rate(16'hFFFF);
		send_word(CMD_INTEG, '0, '1, '0, '0, '0);
		send_word(CMD_SOLVE, '1, '0, '1, '0, '0);
		write_default_rate(16'h0000);
		send_word(CMD_SOLVE, 40'd3, '0, 48'd1, '0, '0);
		send_word(CMD_INTEG, 40'd3, 40'd900, '0, '0, '0);
		write_default_rate(16'd4096);
	endtask

	// one segment: its rate, duration ignored
	task automatic test_single_segment();
		send_word(CMD_APPEND, '0, '0, '0, 24'd50, 16'd3);
		send_word(CMD_RATE, 40'd1000, '0, '0, '0, '0);
		send_word(CMD_SOLVE, 40'd0, '0, 48'd10, '0, '0);
		send_word(CMD_INTEG, 40'd0, 40'd100, '0, '0, '0);
	endtask

	// several segments with a zero-rate one, wrap around, result overflow
	task automatic test_profile();
		send_word(CMD_APPEND, '0, '0, '0, 24'd20, 16'd0);
		send_word(CMD_APPEND, '0, '0, '0, 24'd30, 16'hFFFF);
		send_word(CMD_INTEG, 40'd40, 40'd1000, '0, '0, '0);
		send_word(CMD_SOLVE, 40'd45, '0, 48'd65535, '0, '0);
		send_word(CMD_SOLVE, 40'd60, '0, 48'd200000, '0, '0);
		send_word(CMD_RATE, 40'd75, '0, '0, '0, '0);
		send_word(CMD_INTEG, '0, '1, '0, '0, '0);
		send_word(CMD_SOLVE, '1, '0, '1, '0, '0);
	endtask

	// zero-length period, then a period that does no work
	task automatic test_degenerate();
		send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
		send_word(CMD_APPEND, '0, '0, '0, 24'd0, 16'd9);
		send_word(CMD_APPEND, '0, '0, '0, 24'd0, 16'd7);
		send_word(CMD_INTEG, 40'd1, 40'd5, '0, '0, '0);
		send_word(CMD_SOLVE, 40'd1, '0, 48'd5, '0, '0);
		send_word(CMD_RATE, 40'd1, '0, '0, '0, '0);
		send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
		send_word(CMD_APPEND, '0, '0, '0, 24'd10, 16'd0);
		send_word(CMD_APPEND, '0, '0, '0, 24'd10, 16'd0);
		send_word(CMD_SOLVE, 40'd1, '0, 48'd5, '0, '0);
		send_word(CMD_INTEG, 40'd1, 40'd55, '0, '0, '0);
	endtask

	// fill the table with the largest segments, then one more
	task automatic test_table_full();
		send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
		for (int i = 0; i < SEGS + 1; i++)
			send_word(CMD_APPEND, '0, '0, '0, '1, '1);
		send_word(CMD_INTEG, '0, '1, '0, '0, '0);
		send_word(CMD_SOLVE, TIME_W'({$urandom(), $urandom()}), '0,
			WORK_W'({$urandom(), $urandom()}), '0, '0);
		send_word(CMD_RATE, '1, '0, '0, '0, '0);
	endtask

	// random command mix, phases with different default rates
	task automatic test_random(int unsigned words);
		logic [CMD_W-1:0] c;
		logic [DUR_W-1:0] dur;
		logic [RATE_W-1:0] srate;
		int unsigned p;
		for (int unsigned w = 0; w < words; w++) begin
			if (w % 100 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 3))
					0: write_default_rate('0);
					1: write_default_rate('1);
					default: write_default_rate(RATE_W'($urandom()));
				endcase
			end
			p = $urandom_range(0, 99);
			if (p < 3) c = CMD_CLEAR;
			else if (p < 25) c = CMD_APPEND;
			else if (p < 55) c = CMD_INTEG;
			else if (p < 83) c = CMD_SOLVE;
			else if (p < 96) c = CMD_RATE;
			else c = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
			case ($urandom_range(0, 9))
				0: dur = '0;
				1: dur = DUR_W'($urandom());
				default: dur = DUR_W'($urandom_range(1, 300));
			endcase
			srate = ($urandom_range(0, 7) == 0) ? '0 : RATE_W'($urandom());
			send_word(c, rand_time(), rand_time(), rand_work(), dur, srate);
		end
	endtask

	initial begin
		seg_total = 0; prof_len = 0; prof_work = 0; base_rate = 4096;
		foreach (seg_start[i]) begin seg_start[i] = 0; seg_prefix[i] = 0; end
		foreach (seg_rt[i]) seg_rt[i] = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_fixed_rate();
		test_single_segment();
		test_profile();
		test_degenerate();
		test_table_full();
		test_random(950);
		wait_drained();
		repeat (600) @(posedge clk);
		$display("sent %0d command words, checked %0d results, %0d mismatches",
			words_sent, words_checked, mismatches);
		$display("covered fixed and segment modes, table full, zero rate and overflow");
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
